// ----- rtl/bfa_pkg.sv -----
// Shared types and constants for the best-fit buffer allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

  localparam int unsigned QW  = 16;  // quad count width
  localparam int unsigned ICW = 19;  // index count width
  localparam int unsigned BQW = 18;  // base quad width
  localparam int unsigned INW = 32;  // instance width

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    UPD_HOLD,
    UPD_INS,
    UPD_DEL
  } upd_e;

endpackage
`default_nettype wire

// ----- rtl/bfa_cell.sv -----
// One slot of the region chain: holds a region and passes the search token on.
`timescale 1ns / 1ps
`default_nettype none
module bfa_cell
  import bfa_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned AW    = 17,
  parameter int unsigned IW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          valid_i,
  input  wire logic          op_i,
  input  wire logic [QW-1:0] q_i,
  input  wire logic [QW-1:0] key_i,
  input  wire logic [AW-1:0] prev_end_i,
  input  wire logic          tok_found_i,
  input  wire logic [AW-1:0] tok_space_i,
  input  wire logic [AW-1:0] tok_pos_i,
  input  wire logic [IW-1:0] tok_at_i,
  input  wire logic [AW-1:0] tok_last_i,
  input  wire upd_e          upd_i,
  input  wire logic [IW-1:0] at_i,
  input  wire logic [AW-1:0] new_start_i,
  input  wire logic [QW-1:0] new_size_i,
  input  wire logic [AW-1:0] prev_start_i,
  input  wire logic [QW-1:0] prev_size_i,
  input  wire logic [AW-1:0] next_start_i,
  input  wire logic [QW-1:0] next_size_i,
  output logic [AW-1:0]      start_o,
  output logic [QW-1:0]      size_o,
  output logic [AW-1:0]      end_o,
  output logic               tok_found_o,
  output logic [AW-1:0]      tok_space_o,
  output logic [AW-1:0]      tok_pos_o,
  output logic [IW-1:0]      tok_at_o,
  output logic [AW-1:0]      tok_last_o
);

  localparam int unsigned CMPW = (AW > QW) ? AW : QW;
  localparam logic [IW-1:0] MyIdx = IW'(INDEX);

  logic [AW-1:0] start_q, start_d;
  logic [QW-1:0] size_q, size_d;
  logic [AW-1:0] gap;
  logic          fit, take;

  assign start_o = start_q;
  assign size_o  = size_q;
  assign end_o   = start_q + AW'(size_q);
  assign gap     = start_q - prev_end_i;

  always_comb begin
    fit  = CMPW'(gap) >= CMPW'(q_i);
    take = 1'b0;
    if (valid_i) begin
      if (op_i == OP_FREE) begin
        take = !tok_found_i && (CMPW'(start_q) == CMPW'(key_i));
      end else begin
        take = fit && (!tok_found_i || gap < tok_space_i);
      end
    end
  end

  always_comb begin
    start_d = start_q;
    size_d  = size_q;
    case (upd_i)
      UPD_INS: begin
        if (MyIdx == at_i) begin
          start_d = new_start_i;
          size_d  = new_size_i;
        end else if (MyIdx > at_i) begin
          start_d = prev_start_i;
          size_d  = prev_size_i;
        end
      end
      UPD_DEL: begin
        if (MyIdx >= at_i) begin
          start_d = next_start_i;
          size_d  = next_size_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    size_q      <= size_d;
    tok_found_o <= tok_found_i || take;
    tok_space_o <= take ? gap : tok_space_i;
    tok_pos_o   <= take ? prev_end_i : tok_pos_i;
    tok_at_o    <= take ? MyIdx : tok_at_i;
    tok_last_o  <= valid_i ? end_o : tok_last_i;
  end

endmodule
`default_nettype wire

// ----- rtl/best_fit_buffer_allocator.sv -----
// Top level of the best-fit buffer allocator: control, result register, cell chain.
//
// Usage: items arrive on the s_axis channel. tuser carries the opcode (allocate
// or free), tdata carries quad_count, instance_base and free_base_quad. Each
// item produces exactly one draw-command transaction on m_axis: tuser holds
// the status, tdata holds index_count, base_quad and instance_out.
// Regions live in a row of MAX_REGIONS cells kept sorted by start quad. After
// an item is accepted, a search token walks down the chain one cell per cycle
// (finding the smallest fitting gap or the matching region start). Insertion
// and removal move the cells from the affected position onward by one place
// at once. The result sits in an output register, so the next item is
// accepted while a result waits; if the receiver stalls, the following item
// finishes its walk and then waits until the register is free.
// Reset empties the region list and clears the high-water mark; the region
// storage itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_buffer_allocator
  import bfa_pkg::*;
#(
  parameter int unsigned BUFFER_QUADS = 65536,
  parameter int unsigned QUAD_BYTES   = 32,
  parameter int unsigned MAX_REGIONS  = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // quad_count [15:0], instance_base [47:16], free_base_quad [65:48]
  input  wire logic [71:0] s_axis_tdata_i,
  // opcode [0]
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // index_count [18:0], base_quad [36:19], instance_out [68:37]
  output logic [71:0]      m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]       m_axis_tuser_o
);

  // Sizes are kept in quads throughout, so the quad size in bytes never
  // enters the arithmetic; it only documents the buffer.
  localparam int unsigned BufBytes = BUFFER_QUADS * QUAD_BYTES;
  localparam int unsigned AW   = $clog2(BUFFER_QUADS + 1);
  localparam int unsigned IW   = $clog2(MAX_REGIONS);
  localparam int unsigned NW   = $clog2(MAX_REGIONS + 1);
  localparam int unsigned CMPW = ((AW > QW) ? AW : QW) + 1;
  localparam logic [CMPW-1:0] BufLim = CMPW'(BUFFER_QUADS);
  localparam logic [NW-1:0]   NMax   = NW'(MAX_REGIONS);
  localparam logic [IW-1:0]   ScanEnd = IW'(MAX_REGIONS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [IW-1:0]  cnt_q;
  logic [NW-1:0]  count_q, count_d;
  logic [AW-1:0]  hw_q, hw_d;
  logic           op_q;
  logic [QW-1:0]  q_q, key_q;
  logic [INW-1:0] inst_q;

  logic           m_valid_q;
  logic [71:0]    m_data_q, m_data_d;
  logic [1:0]     m_user_q, m_user_d;

  logic           s_fire, fin_go;
  upd_e           upd;
  logic [IW-1:0]  upd_at;
  logic [AW-1:0]  new_start;

  logic [AW-1:0] c_start [MAX_REGIONS];
  logic [QW-1:0] c_size  [MAX_REGIONS];
  logic [AW-1:0] c_end   [MAX_REGIONS];
  logic          t_found [MAX_REGIONS];
  logic [AW-1:0] t_space [MAX_REGIONS];
  logic [AW-1:0] t_pos   [MAX_REGIONS];
  logic [IW-1:0] t_at    [MAX_REGIONS];
  logic [AW-1:0] t_last  [MAX_REGIONS];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign fin_go          = (state_q == S_FIN) && (!m_valid_q || m_axis_tready_i);

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // The cell chain. Cell 0 sees an empty token and a previous end of zero.
  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    localparam int unsigned Prev = (i == 0) ? 0 : i - 1;
    localparam int unsigned Next = (i == MAX_REGIONS - 1) ? i : i + 1;
    bfa_cell #(
      .INDEX(i),
      .AW   (AW),
      .IW   (IW)
    ) u_cell (
      .clk_i       (clk_i),
      .valid_i     (NW'(i) < count_q),
      .op_i        (op_q),
      .q_i         (q_q),
      .key_i       (key_q),
      .prev_end_i  ((i == 0) ? '0 : c_end[Prev]),
      .tok_found_i ((i == 0) ? 1'b0 : t_found[Prev]),
      .tok_space_i ((i == 0) ? '0 : t_space[Prev]),
      .tok_pos_i   ((i == 0) ? '0 : t_pos[Prev]),
      .tok_at_i    ((i == 0) ? '0 : t_at[Prev]),
      .tok_last_i  ((i == 0) ? '0 : t_last[Prev]),
      .upd_i       (upd),
      .at_i        (upd_at),
      .new_start_i (new_start),
      .new_size_i  (q_q),
      .prev_start_i(c_start[Prev]),
      .prev_size_i (c_size[Prev]),
      .next_start_i(c_start[Next]),
      .next_size_i (c_size[Next]),
      .start_o     (c_start[i]),
      .size_o      (c_size[i]),
      .end_o       (c_end[i]),
      .tok_found_o (t_found[i]),
      .tok_space_o (t_space[i]),
      .tok_pos_o   (t_pos[i]),
      .tok_at_o    (t_at[i]),
      .tok_last_o  (t_last[i])
    );
  end

  // Final decision, taken once the token has left the last cell.
  logic [CMPW-1:0] hw_sum, last_sum;
  logic [AW-1:0]   last_pos;
  logic [ICW-1:0]  idx_cnt;
  logic [CMPW-1:0] start_ext;

  always_comb begin
    hw_sum   = CMPW'(hw_q) + CMPW'(q_q);
    last_pos = (count_q == '0) ? '0 : t_last[MAX_REGIONS-1];
    last_sum = CMPW'(last_pos) + CMPW'(q_q);
    idx_cnt  = (ICW'(q_q) << 2) + (ICW'(q_q) << 1);

    upd       = UPD_HOLD;
    upd_at    = IW'(count_q);
    new_start = hw_q;
    count_d   = count_q;
    hw_d      = hw_q;
    m_user_d  = ST_OK;
    if (op_q == OP_FREE) begin
      if (t_found[MAX_REGIONS-1]) begin
        upd     = UPD_DEL;
        upd_at  = t_at[MAX_REGIONS-1];
        count_d = count_q - 1'b1;
      end else begin
        m_user_d = ST_NOTFOUND;
      end
    end else if (count_q == NMax) begin
      m_user_d = ST_FULL;
    end else if (hw_sum < BufLim) begin
      upd     = UPD_INS;
      count_d = count_q + 1'b1;
      hw_d    = AW'(hw_sum);
    end else if (t_found[MAX_REGIONS-1]) begin
      upd       = UPD_INS;
      upd_at    = t_at[MAX_REGIONS-1];
      new_start = t_pos[MAX_REGIONS-1];
      count_d   = count_q + 1'b1;
    end else if (last_sum > BufLim) begin
      m_user_d = ST_NOSPACE;
    end else begin
      upd       = UPD_INS;
      new_start = last_pos;
      count_d   = count_q + 1'b1;
      if (last_sum > CMPW'(hw_q)) begin
        hw_d = AW'(last_sum);
      end
    end

    start_ext = CMPW'(new_start);
    if (upd == UPD_INS) begin
      m_data_d = {3'b000, inst_q, start_ext[BQW-3:0], 2'b00, idx_cnt};
    end else begin
      m_data_d = '0;
    end
    if (!fin_go) begin
      upd = UPD_HOLD;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q == ScanEnd) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      count_q   <= '0;
      hw_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (fin_go) begin
        count_q   <= count_d;
        hw_q      <= hw_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q   <= s_axis_tuser_i;
      q_q    <= s_axis_tdata_i[15:0];
      inst_q <= s_axis_tdata_i[47:16];
      key_q  <= s_axis_tdata_i[65:50];
    end
    if (fin_go) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
    end
  end

  // The region list never grows past the table.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NMax)
    else $error("region count exceeds table size (%0d bytes buffer)", BufBytes);

  // The high-water mark stays inside the buffer.
  a_hw_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(hw_q) <= BufLim)
    else $error("high-water mark beyond buffer");

  // Items enter only while the chain is free.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> (state_q == S_IDLE) && (cnt_q == '0))
    else $error("item accepted during a scan");

  // A successful free removes exactly one region.
  a_free_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && (op_q == OP_FREE) && t_found[MAX_REGIONS-1])
      |=> count_q == $past(count_q) - 1'b1)
    else $error("free did not shrink the region list");

endmodule
`default_nettype wire

// ----- verif/bfa_checker.sv -----
// Checker for the best-fit buffer allocator: predicts draw commands and compares them.
`timescale 1ns / 1ps
module bfa_checker
  import bfa_pkg::*;
#(
  parameter int unsigned BUFFER_QUADS = 65536,
  parameter int unsigned MAX_REGIONS  = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  input  wire logic        s_ready_i,
  input  wire logic [71:0] s_data_i,
  input  wire logic        s_user_i,
  input  wire logic        m_valid_i,
  input  wire logic        m_ready_i,
  input  wire logic [71:0] m_data_i,
  input  wire logic [1:0]  m_user_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [18:0] index_count;
    logic [17:0] base_quad;
    logic [31:0] instance_out;
  } draw_cmd_t;

  int unsigned used_start[$];
  int unsigned used_size[$];
  int unsigned hwm;
  draw_cmd_t   cmd_queue[$];

  assign pending_o = cmd_queue.size();

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  function automatic draw_cmd_t place(int unsigned at, int unsigned start,
                                      int unsigned q, logic [31:0] inst);
    draw_cmd_t c;
    used_start.insert(at, start);
    used_size.insert(at, q);
    c.status = ST_OK;
    c.index_count = 19'(q * 6);
    c.base_quad = 18'(start << 2);
    c.instance_out = inst;
    return c;
  endfunction

  function automatic draw_cmd_t allocate_or_free(logic op, logic [71:0] d);
    draw_cmd_t   c;
    int unsigned q, key, pos, sp, best_pos, best_sp, best_at, n;
    bit          found;
    c = '0;
    q = d[15:0];
    key = d[65:48] >> 2;
    n = used_start.size();
    if (op == OP_FREE) begin
      c.status = ST_NOTFOUND;
      for (int i = 0; i < n; i++) begin
        if (used_start[i] == key) begin
          used_start.delete(i);
          used_size.delete(i);
          c.status = ST_OK;
          break;
        end
      end
      return c;
    end
    if (n >= MAX_REGIONS) begin
      c.status = ST_FULL;
      return c;
    end
    if (longint'(hwm) + q < longint'(BUFFER_QUADS)) begin
      c = place(n, hwm, q, d[47:16]);
      hwm = hwm + q;
      return c;
    end
    found = 0;
    best_pos = 0; best_sp = 0; best_at = 0;
    if (n > 0) begin
      if (used_start[0] >= q) begin
        found = 1; best_sp = used_start[0];
      end
      for (int i = 1; i < n; i++) begin
        pos = used_start[i-1] + used_size[i-1];
        sp = used_start[i] - pos;
        if (sp >= q && (!found || sp < best_sp)) begin
          found = 1; best_pos = pos; best_sp = sp; best_at = i;
        end
      end
    end
    if (found) return place(best_at, best_pos, q, d[47:16]);
    pos = (n > 0) ? used_start[n-1] + used_size[n-1] : 0;
    if (longint'(pos) + q > longint'(BUFFER_QUADS)) begin
      c.status = ST_NOSPACE;
      return c;
    end
    c = place(n, pos, q, d[47:16]);
    if (pos + q > hwm) hwm = pos + q;
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    draw_cmd_t w;
    if (!rst_ni) begin
      used_start.delete();
      used_size.delete();
      cmd_queue.delete();
      hwm = 0;
      fail_count_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (cmd_queue.size() == 0) begin
          report_mismatch("unexpected transaction", m_user_i, 0);
        end else begin
          w = cmd_queue.pop_front();
          if (m_user_i != w.status) report_mismatch("status", m_user_i, w.status);
          if (m_data_i[18:0] != w.index_count)
            report_mismatch("index_count", m_data_i[18:0], w.index_count);
          if (m_data_i[36:19] != w.base_quad)
            report_mismatch("base_quad", m_data_i[36:19], w.base_quad);
          if (m_data_i[68:37] != w.instance_out)
            report_mismatch("instance_out", m_data_i[68:37], w.instance_out);
        end
      end
      if (s_valid_i && s_ready_i)
        cmd_queue.insert(cmd_queue.size(), allocate_or_free(s_user_i, s_data_i));
    end
  end

endmodule

// ----- verif/tb_best_fit_buffer_allocator.sv -----
// Testbench top: drives allocate and free items into the allocator and gives the verdict.
`timescale 1ns / 1ps
module tb_best_fit_buffer_allocator;
  import bfa_pkg::*;

  localparam int unsigned MAX_REGIONS = 256;
  // An item walks the whole chain before its result appears.
  localparam int unsigned LATENCY     = MAX_REGIONS + 2;
  // Idle cycles allowed: a long receiver hold plus two walks, several times over.
  localparam int unsigned IDLE_LIMIT  = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [71:0] in_data = '0;
  logic        in_user = OP_ALLOC;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [71:0] out_data;
  logic [1:0]  out_user;
  int          fail_count;
  int          pending;
  bit          hold_off = 0;
  int unsigned idle_cycles = 0;
  int unsigned known_bases[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  best_fit_buffer_allocator u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(in_valid), .s_axis_tready_o(in_ready),
    .s_axis_tdata_i(in_data), .s_axis_tuser_i(in_user),
    .m_axis_tvalid_o(out_valid), .m_axis_tready_i(out_ready),
    .m_axis_tdata_o(out_data), .m_axis_tuser_o(out_user)
  );

  bfa_checker #(.MAX_REGIONS(MAX_REGIONS)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .s_valid_i(in_valid), .s_ready_i(in_ready), .s_data_i(in_data), .s_user_i(in_user),
    .m_valid_i(out_valid), .m_ready_i(out_ready), .m_data_i(out_data),
    .m_user_i(out_user), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Remember bases handed out so that most frees name a live region.
  always @(posedge clk) begin
    if (out_valid && out_ready && out_user == ST_OK && out_data[18:0] != 0)
      known_bases.insert(known_bases.size(), out_data[36:19]);
  end

  // One item per call: the valid stays high across back-to-back items and is
  // only lowered when a gap follows.
  task automatic offer(input logic op, input int unsigned q, input logic [31:0] inst,
                       input logic [17:0] fbq, input bit gap_after);
    @(posedge clk);
    in_valid <= 1'b1;
    in_user  <= op;
    in_data  <= {6'd0, fbq, inst, q[15:0]};
    do @(posedge clk); while (!in_ready);
    if (gap_after) in_valid <= 1'b0;
  endtask

  task automatic send_item(input logic op, input int unsigned q, input logic [17:0] fbq,
                           input bit gap_after);
    offer(op, q, $urandom(), fbq, gap_after);
  endtask

  // Receiver: a random stall pattern and one long hold-off while the sender
  // keeps offering items.
  initial begin
    int unsigned mode;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        mode = $urandom_range(0, 99);
        out_ready <= (mode < 70) ? 1'b1 : 1'b0;
      end
    end
  end

  initial begin
    hold_off = 0;
    repeat (200) @(posedge clk);
    wait (rst_n);
    repeat (3000) @(posedge clk);
    hold_off = 1;
    repeat (2000) @(posedge clk);
    hold_off = 0;
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_best_fit_buffer_allocator NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned burst, q, pick;
    logic [17:0] fbq;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: empty-list free, zero request, extremes, exhausted space
    // and a miss on free.
    send_item(OP_FREE, 0, 18'h3FFFF, 1);
    send_item(OP_ALLOC, 0, 0, 1);
    send_item(OP_ALLOC, 1, 0, 0);
    offer(OP_ALLOC, 10, 32'hFFFFFFFF, 18'h3FFFF, 0);
    offer(OP_ALLOC, 5, 32'h0, 0, 1);
    send_item(OP_ALLOC, 65535, 0, 1);       // does not fit above the mark: append fails
    send_item(OP_FREE, 0, 18'd4, 1);        // frees the region at quad 1
    send_item(OP_ALLOC, 65000, 0, 1);
    send_item(OP_ALLOC, 1, 0, 1);           // still fits above the high-water mark
    send_item(OP_FREE, 0, 18'd44, 1);
    send_item(OP_ALLOC, 3, 0, 1);
    send_item(OP_ALLOC, 65535, 0, 1);
    send_item(OP_FREE, 0, 18'd3, 1);        // low bits dropped from the key
    for (int i = 0; i < 8; i++) send_item(OP_FREE, 0, 18'(i * 4), 0);
    send_item(OP_FREE, 0, 18'd44 * 100, 1);

    // Fill the table with small regions to reach the full status.
    for (int i = 0; i < MAX_REGIONS + 4; i++) send_item(OP_ALLOC, $urandom_range(0, 3), 0, 0);

    // Random: mostly frees of known bases and small allocations, some noise.
    for (int n = 0; n < 970; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++, n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          if (known_bases.size() > 0 && $urandom_range(0, 9) < 8) begin
            fbq = 18'(known_bases[$urandom_range(0, known_bases.size() - 1)]
                      | $urandom_range(0, 3));
          end else begin
            fbq = 18'($urandom());
          end
          offer(OP_FREE, $urandom(), $urandom(), fbq, b == burst - 1);
        end else begin
          q = (pick < 90) ? $urandom_range(0, 600) : $urandom_range(0, 65535);
          offer(OP_ALLOC, q, $urandom(), 18'($urandom()), b == burst - 1);
        end
      end
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end

    @(posedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_best_fit_buffer_allocator OK");
    end else begin
      $display("tb_best_fit_buffer_allocator NOT OK");
    end
    $finish;
  end

endmodule
